// ===== sv/fmcd_pkg.sv =====
// Package for the framed motor command deframer.
// Frame constants, phase encoding and the stage-to-stage frame word type.
// No dependencies.
package fmcd_pkg;

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] TRL_BYTE    = 8'hFE;
    localparam logic [7:0] ANGLE_MARK  = 8'hFF;
    localparam int         PAYLOAD_LEN = 6;
    localparam int         CNT_W       = $clog2(PAYLOAD_LEN + 1);

    localparam logic KIND_ANGLE = 1'b0;
    localparam logic KIND_SPEED = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_COLLECT = 3'b010,
        PH_WAIT    = 3'b100
    } phase_t;

    typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

    // complete frame seen on the current word, plus its payload
    typedef struct packed {
        logic     done;
        payload_t payload;
    } frame_t;

endpackage

// ===== sv/fmcd_frame_fsm.sv =====
// Frame tracker: header hunt, payload collection and trailer wait.
// Flags a good frame on the trailer word. Depends on fmcd_pkg.
module fmcd_frame_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_valid,
    input  logic              step,
    input  logic [7:0]        word,
    output fmcd_pkg::frame_t  frame
);

    fmcd_pkg::phase_t                 phase_reg, phase_next;
    logic [fmcd_pkg::CNT_W-1:0]       count_reg, count_next;
    fmcd_pkg::payload_t               store_reg;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        unique case (phase_reg)
            fmcd_pkg::PH_COLLECT:
            begin
                count_next = count_reg + 1'b1;
                if (count_next >= fmcd_pkg::CNT_W'(fmcd_pkg::PAYLOAD_LEN))
                begin
                    phase_next = fmcd_pkg::PH_WAIT;
                end
            end
            fmcd_pkg::PH_WAIT:
            begin
                if (word == fmcd_pkg::TRL_BYTE)
                begin
                    phase_next = fmcd_pkg::PH_HUNT;
                end
            end
            default:
            begin
                phase_next = fmcd_pkg::PH_HUNT;
                if (word == fmcd_pkg::HDR_BYTE)
                begin
                    phase_next = fmcd_pkg::PH_COLLECT;
                    count_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fmcd_pkg::PH_HUNT;
            count_reg <= '0;
        end
        else if (word_valid && step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_valid && step && phase_reg == fmcd_pkg::PH_COLLECT
            && count_reg < fmcd_pkg::CNT_W'(fmcd_pkg::PAYLOAD_LEN))
        begin
            store_reg[count_reg[$clog2(fmcd_pkg::PAYLOAD_LEN)-1:0]] <= word;
        end
    end

    assign frame.done    = word_valid && phase_reg == fmcd_pkg::PH_WAIT
                           && word == fmcd_pkg::TRL_BYTE;
    assign frame.payload = store_reg;

endmodule

// ===== sv/fmcd_cmd_update.sv =====
// Command decode: updates held angles or speeds on a good frame and
// holds the result word until taken. Depends on fmcd_pkg.
module fmcd_cmd_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  fmcd_pkg::frame_t    frame,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                frame_kind,
    output logic [7:0]          angle_first,
    output logic [7:0]          angle_second,
    output logic signed [15:0]  left_speed,
    output logic signed [15:0]  right_speed
);

    logic [7:0]  angle_a_reg, angle_a_next;
    logic [7:0]  angle_b_reg, angle_b_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] right_reg, right_next;
    logic        kind_next;
    logic        valid_reg;
    logic        kind_reg;
    logic [15:0] left_raw, right_raw;
    logic        load;

    assign left_raw  = {frame.payload[1], frame.payload[2]};
    assign right_raw = {frame.payload[4], frame.payload[5]};
    assign load      = step && frame.done;

    always_comb
    begin
        angle_a_next = angle_a_reg;
        angle_b_next = angle_b_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        if (frame.payload[1] == fmcd_pkg::ANGLE_MARK)
        begin
            kind_next    = fmcd_pkg::KIND_ANGLE;
            angle_a_next = frame.payload[2];
            angle_b_next = frame.payload[3];
        end
        else
        begin
            kind_next  = fmcd_pkg::KIND_SPEED;
            left_next  = (frame.payload[0] != 8'h00) ? 16'(-left_raw)  : left_raw;
            right_next = (frame.payload[3] != 8'h00) ? 16'(-right_raw) : right_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_a_reg <= '0;
            angle_b_reg <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                angle_a_reg <= angle_a_next;
                angle_b_reg <= angle_b_next;
                left_reg    <= left_next;
                right_reg   <= right_next;
                valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
        end
    end

    assign out_valid    = valid_reg;
    assign frame_kind   = kind_reg;
    assign angle_first  = angle_a_reg;
    assign angle_second = angle_b_reg;
    assign left_speed   = left_reg;
    assign right_speed  = right_reg;

endmodule

// ===== sv/framed_motor_command_deframer_unit.sv =====
// Path: trailer word into the input word register, then the result registers.
// Throughput: one input word per cycle; the input stalls only while a finished
// result is held and the word in the input register completes another frame.
// Reset (rst_n, async, active low): header hunt, held angles and speeds zero.
// Depends on fmcd_pkg, fmcd_frame_fsm, fmcd_cmd_update.
module framed_motor_command_deframer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_kind,
    output logic [7:0]         angle_first,
    output logic [7:0]         angle_second,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed
);

    logic             word_valid_reg;
    logic [7:0]       word_reg;
    logic             hold;
    logic             step;
    fmcd_pkg::frame_t frame;

    assign hold     = frame.done && out_valid && out_stall;
    assign step     = !hold;
    assign in_stall = hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            word_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && step)
        begin
            word_reg <= rx_byte;
        end
    end

    fmcd_frame_fsm u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid_reg),
        .step       (step),
        .word       (word_reg),
        .frame      (frame)
    );

    fmcd_cmd_update u_cmd (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .frame        (frame),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .frame_kind   (frame_kind),
        .angle_first  (angle_first),
        .angle_second (angle_second),
        .left_speed   (left_speed),
        .right_speed  (right_speed)
    );

endmodule

// ===== sv/fmcd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends only on the top level's ports.
module fmcd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               frame_kind,
    input logic [7:0]         angle_first,
    input logic [7:0]         angle_second,
    input logic signed [15:0] left_speed,
    input logic signed [15:0] right_speed
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result word valid during reset");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no blocked result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result word without a trailer word two cycles before");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(frame_kind)
            && $stable(angle_first) && $stable(angle_second)
            && $stable(left_speed) && $stable(right_speed)))
        else $error("stalled result word changed");

endmodule

bind framed_motor_command_deframer_unit fmcd_checker u_fmcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_kind   (frame_kind),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .left_speed   (left_speed),
    .right_speed  (right_speed)
);
